/* src/temperature_history_tracker_core_macros.svh */
// Assertion macros shared by the temperature history tracker RTL.
// Needs signals named clk and rst in the scope of each use.
`ifndef TEMPERATURE_HISTORY_TRACKER_CORE_MACROS_SVH
`define TEMPERATURE_HISTORY_TRACKER_CORE_MACROS_SVH

// Check a consequence in the same cycle as its cause
`define THTC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its cause
`define THTC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/thtc_pkg.sv */
// Constants, codes and types of the temperature history tracker.
// No dependencies; used by the interfaces and the top level.
`default_nettype none

package thtc_pkg;

  // Block sizing
  localparam int HISTORY_DEPTH = 240;
  localparam int AVG_COUNT     = 6;
  localparam int GRAPH_ROWS    = 32;

  localparam int HIST_AW = $clog2(HISTORY_DEPTH);
  localparam int RIDX_W  = $clog2(AVG_COUNT);

  // Transaction field widths
  localparam int RAW_W      = 16;
  localparam int COLUMN_W   = 8;
  localparam int WHOLE_W    = 7;
  localparam int TENTHS_W   = 4;
  localparam int HALF_W     = 8;
  localparam int ROW_OUT_W  = 5;
  localparam int SCALE_W    = 7;
  localparam int FLOOR_W    = 8;
  localparam int CEIL_W     = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Sensor word conversion
  localparam int RAW_LOW_W = 12;
  localparam int MAG_W     = 13;
  localparam logic [MAG_W-1:0] MAG_SPAN = 13'h1000;
  localparam int FRAC_W    = 4;
  localparam int TPROD_W   = 8;
  localparam logic [TPROD_W-1:0] TENTHS_SCALE = 8'd10;
  localparam int WHOLE_MAX    = 127;
  localparam int HALF_POS_MAX = 127;
  localparam int HALF_NEG_MAX = 128;
  localparam logic signed [HALF_W-1:0] HALF_MOST_NEG = 8'sh80;

  // Averaging: accumulator and reciprocal multiply
  localparam int ACC_W       = HALF_W + $clog2(AVG_COUNT);
  localparam int RECIP_SH    = 18;
  localparam int RECIP       = (2**RECIP_SH + AVG_COUNT - 1) / AVG_COUNT;
  localparam int PROD_W      = ACC_W + RECIP_SH;
  localparam int AVG_Q_W     = HALF_W + 1;
  localparam int REFRESH_MID = AVG_COUNT / 2 - 1;

  // Graph scaling and row division
  localparam int LVL_W   = 9;
  localparam int DIFF_W  = 9;
  localparam int ROW_W   = $clog2(GRAPH_ROWS);
  localparam int DVD_W   = DIFF_W + ROW_W;
  localparam int DCNT_W  = $clog2(DVD_W);
  localparam int ALU_W   = (ACC_W > DIFF_W + 1) ? ACC_W + 1 : DIFF_W + 2;

  // Opcodes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  // Register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_FLOOR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_CEILING = 2'd1;
  localparam logic signed [FLOOR_W-1:0] FLOOR_RESET  = 8'sd0;
  localparam logic [CEIL_W-1:0] CEILING_RESET        = 7'd20;

  // Shared adder operation
  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  // Sequencer states
  typedef enum logic [8:0] {
    ST_IDLE     = 9'b000000001,
    ST_SUM      = 9'b000000010,
    ST_AVG_MUL  = 9'b000000100,
    ST_AVG_WR   = 9'b000001000,
    ST_SCAN     = 9'b000010000,
    ST_SCAN_END = 9'b000100000,
    ST_FETCH    = 9'b001000000,
    ST_DIVR     = 9'b010000000,
    ST_DONE     = 9'b100000000
  } state_t;

endpackage

`default_nettype wire

/* src/thtc_if.sv */
// Handshake interfaces of the temperature history tracker: request,
// result and register write channels. Depends on thtc_pkg.
`default_nettype none

interface thtc_req_if import thtc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                opcode;
  logic [RAW_W-1:0]    raw_sample;
  logic [COLUMN_W-1:0] column;

  modport source (output valid, opcode, raw_sample, column, input ready);
  modport sink   (input valid, opcode, raw_sample, column, output ready);
endinterface

interface thtc_rsp_if import thtc_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       sensor_error;
  logic                       is_negative;
  logic [WHOLE_W-1:0]         whole_degrees;
  logic [TENTHS_W-1:0]        tenths;
  logic signed [HALF_W-1:0]   half_degrees;
  logic                       refresh_due;
  logic [ROW_OUT_W-1:0]       graph_row;
  logic signed [SCALE_W-1:0]  scale_min_whole;
  logic signed [SCALE_W-1:0]  scale_max_whole;

  modport source (output valid, sensor_error, is_negative, whole_degrees, tenths,
                  half_degrees, refresh_due, graph_row, scale_min_whole,
                  scale_max_whole, input ready);
  modport sink   (input valid, sensor_error, is_negative, whole_degrees, tenths,
                  half_degrees, refresh_due, graph_row, scale_min_whole,
                  scale_max_whole, output ready);
endinterface

interface thtc_cfg_if import thtc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* src/temperature_history_tracker_core.sv */
// Top level of the temperature history tracker: sample conversion, averaging
// into the history ring, and graph queries. Depends on thtc_pkg, thtc_if,
// thtc_ram and the assertion macro header.
`default_nettype none

`include "temperature_history_tracker_core_macros.svh"

// Each request transaction yields exactly one result transaction. A sample
// (opcode 0) is converted in the accept cycle; its result goes through
// ST_DONE to the output register, by way of ST_SUM, ST_AVG_MUL and ST_AVG_WR
// first when it completes a group: the average is summed by the shared adder
// (one entry per cycle) and written to the history ring. A zero sample word
// only flags sensor_error. A graph query (opcode 1) reads the whole ring
// once through the single RAM read port, one entry per cycle, then, unless
// the scale span is zero, divides on the shared adder one quotient bit per
// cycle. request.ready is high only while the sequencer is idle; a finished
// result waits in its output register while the next request is accepted.
// The ring reads as zero until written, so no clearing pass follows reset.
// Register writes are taken in any cycle.
module temperature_history_tracker_core import thtc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  thtc_req_if.sink   request,
  thtc_rsp_if.source result,
  thtc_cfg_if.sink   cfg
);

  // Configuration registers
  logic signed [FLOOR_W-1:0] scale_floor;
  logic [CEIL_W-1:0]         scale_ceiling;

  // Sequencer and counters
  state_t              state;
  logic [RIDX_W-1:0]   ridx;
  logic [RIDX_W-1:0]   sum_cnt;
  logic [HIST_AW-1:0]  write_pos;
  logic [HIST_AW-1:0]  scan_cnt;
  logic                scan_pend;
  logic [DCNT_W-1:0]   div_cnt;

  // Sample buffer and averaging datapath
  logic signed [HALF_W-1:0] recent [AVG_COUNT];
  logic signed [ACC_W-1:0]  acc;
  logic                     avg_neg;
  logic [PROD_W-1:0]        prod;

  // History ring
  logic [HISTORY_DEPTH-1:0] ring_valid;
  logic                     ring_we;
  logic [HIST_AW-1:0]       rd_addr;
  logic [HALF_W-1:0]        rd_data;
  logic                     rd_valid_q;
  logic [HIST_AW-1:0]       col_idx;

  // Scale limits and row division
  logic signed [LVL_W-1:0] lo;
  logic signed [LVL_W-1:0] hi;
  logic [DVD_W-1:0]        dvd;
  logic [DIFF_W-1:0]       divisor;
  logic [DIFF_W-1:0]       rem;
  logic [DVD_W-1:0]        quot;

  // Result staging
  logic                      res_error;
  logic                      res_neg;
  logic [WHOLE_W-1:0]        res_whole;
  logic [TENTHS_W-1:0]       res_tenths;
  logic signed [HALF_W-1:0]  res_half;
  logic                      res_refresh;
  logic [ROW_OUT_W-1:0]      res_row;
  logic signed [SCALE_W-1:0] res_min;
  logic signed [SCALE_W-1:0] res_max;

  // Output register
  logic                      out_valid;
  logic                      out_load;

  // ---------------------------------------------------------------------
  // Sample conversion (combinational on the request payload)
  // ---------------------------------------------------------------------
  logic [RAW_LOW_W-1:0]     raw_low;
  logic                     raw_neg;
  logic [MAG_W-1:0]         mag;
  logic [MAG_W-FRAC_W-1:0]  whole_raw;
  logic [TPROD_W-1:0]       tenths_prod;
  logic [MAG_W-4:0]         half_mag;
  logic [WHOLE_W-1:0]       conv_whole;
  logic [TENTHS_W-1:0]      conv_tenths;
  logic signed [HALF_W-1:0] conv_half;
  logic                     conv_refresh;

  assign raw_low     = request.raw_sample[RAW_LOW_W-1:0];
  assign raw_neg     = raw_low[RAW_LOW_W-1];
  assign mag         = raw_neg ? MAG_SPAN - {1'b0, raw_low} : {1'b0, raw_low};
  assign whole_raw   = mag[MAG_W-1:FRAC_W];
  assign tenths_prod = TPROD_W'(mag[FRAC_W-1:0]) * TENTHS_SCALE;
  assign half_mag    = mag[MAG_W-1:3];

  // Saturate whole degrees and half degrees
  always_comb begin
    if (whole_raw > (MAG_W-FRAC_W)'(WHOLE_MAX)) begin
      conv_whole = WHOLE_W'(WHOLE_MAX);
    end else begin
      conv_whole = whole_raw[WHOLE_W-1:0];
    end
    if (raw_neg) begin
      if (half_mag > (MAG_W-3)'(HALF_NEG_MAX)) begin
        conv_half = HALF_MOST_NEG;
      end else begin
        conv_half = HALF_W'(-half_mag);
      end
    end else begin
      if (half_mag > (MAG_W-3)'(HALF_POS_MAX)) begin
        conv_half = HALF_W'(HALF_POS_MAX);
      end else begin
        conv_half = half_mag[HALF_W-1:0];
      end
    end
  end

  assign conv_tenths  = tenths_prod[TPROD_W-1:TPROD_W-TENTHS_W];
  assign conv_refresh = (ridx == RIDX_W'(REFRESH_MID)) || (ridx == RIDX_W'(AVG_COUNT - 1));

  // ---------------------------------------------------------------------
  // Query column: clamp and rotate so that column 0 is the oldest entry
  // ---------------------------------------------------------------------
  logic [HIST_AW-1:0] col_clamped;
  logic [HIST_AW:0]   idx_sum;
  logic [HIST_AW:0]   idx_wrapped;

  assign col_clamped = (request.column >= COLUMN_W'(HISTORY_DEPTH)) ?
                       HIST_AW'(HISTORY_DEPTH - 1) : HIST_AW'(request.column);
  assign idx_sum     = (HIST_AW+1)'(col_clamped) + (HIST_AW+1)'(write_pos);
  assign idx_wrapped = (idx_sum >= (HIST_AW+1)'(HISTORY_DEPTH)) ?
                       idx_sum - (HIST_AW+1)'(HISTORY_DEPTH) : idx_sum;

  // ---------------------------------------------------------------------
  // Shared adder: accumulates the average and trial-subtracts in division
  // ---------------------------------------------------------------------
  alu_op_t                  alu_op;
  logic [ALU_W-1:0]         alu_a;
  logic [ALU_W-1:0]         alu_b;
  logic [ALU_W-1:0]         alu_y;
  logic [DIFF_W:0]          rem_sh;
  logic                     div_ge;
  logic                     div_last;

  assign rem_sh = {rem, dvd[DVD_W-1]};

  always_comb begin
    if (state == ST_DIVR) begin
      alu_op = ALU_SUB;
      alu_a  = ALU_W'(rem_sh);
      alu_b  = ALU_W'(divisor);
    end else begin
      alu_op = ALU_ADD;
      alu_a  = ALU_W'(acc);
      alu_b  = ALU_W'(recent[sum_cnt]);
    end
  end

  always_comb begin
    case (alu_op)
      ALU_SUB: alu_y = alu_a - alu_b;
      default: alu_y = alu_a + alu_b;
    endcase
  end

  assign div_ge   = !alu_y[ALU_W-1];
  assign div_last = (div_cnt == DCNT_W'(DVD_W - 1));

  // ---------------------------------------------------------------------
  // Average: magnitude times reciprocal, sign restored on write
  // ---------------------------------------------------------------------
  logic [ACC_W-1:0]         acc_mag;
  logic [AVG_Q_W-1:0]       avg_q;
  logic [HALF_W-1:0]        avg_val;

  assign acc_mag = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
  assign avg_q   = prod[RECIP_SH +: AVG_Q_W];
  assign avg_val = avg_neg ? HALF_W'(-avg_q) : avg_q[HALF_W-1:0];

  // ---------------------------------------------------------------------
  // History ring storage
  // ---------------------------------------------------------------------
  assign ring_we = (state == ST_AVG_WR);
  assign rd_addr = (state == ST_SCAN) ? scan_cnt : col_idx;

  thtc_ram #(
    .WIDTH (HALF_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (write_pos),
    .wdata (avg_val),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Unwritten entries read as zero
  logic signed [LVL_W-1:0] ring_v;
  logic signed [LVL_W:0]   d_full;
  logic signed [LVL_W:0]   diff_full;
  logic [DIFF_W-1:0]       d_clamped;

  assign ring_v    = rd_valid_q ? LVL_W'($signed(rd_data)) : '0;
  assign d_full    = (LVL_W+1)'(ring_v) - (LVL_W+1)'(lo);
  assign diff_full = (LVL_W+1)'(hi) - (LVL_W+1)'(lo);
  assign d_clamped = d_full[LVL_W] ? '0 : d_full[DIFF_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_valid <= '0;
    end else if (ring_we) begin
      ring_valid[write_pos] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rd_valid_q <= ring_valid[rd_addr];
  end

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_floor   <= FLOOR_RESET;
      scale_ceiling <= CEILING_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_SCALE_FLOOR:   scale_floor   <= FLOOR_W'(cfg.data);
        REG_SCALE_CEILING: scale_ceiling <= cfg.data[CEIL_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer control
  // ---------------------------------------------------------------------
  assign request.ready = (state == ST_IDLE);
  assign out_load      = (state == ST_DONE) && (!out_valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ridx      <= '0;
      write_pos <= '0;
      scan_pend <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (request.valid) begin
            if (request.opcode == OP_QUERY) begin
              state <= ST_SCAN;
            end else if (request.raw_sample == '0) begin
              state <= ST_DONE;
            end else if (ridx == RIDX_W'(AVG_COUNT - 1)) begin
              ridx  <= '0;
              state <= ST_SUM;
            end else begin
              ridx  <= ridx + 1'b1;
              state <= ST_DONE;
            end
          end
        end
        ST_SUM: begin
          if (sum_cnt == RIDX_W'(AVG_COUNT - 1)) begin
            state <= ST_AVG_MUL;
          end
        end
        ST_AVG_MUL: state <= ST_AVG_WR;
        ST_AVG_WR: begin
          if (write_pos == HIST_AW'(HISTORY_DEPTH - 1)) begin
            write_pos <= '0;
          end else begin
            write_pos <= write_pos + 1'b1;
          end
          state <= ST_DONE;
        end
        ST_SCAN: begin
          scan_pend <= 1'b1;
          if (scan_cnt == HIST_AW'(HISTORY_DEPTH - 1)) begin
            state <= ST_SCAN_END;
          end
        end
        ST_SCAN_END: begin
          scan_pend <= 1'b0;
          state     <= ST_FETCH;
        end
        ST_FETCH: begin
          if (diff_full == '0) begin
            state <= ST_DONE;
          end else begin
            state <= ST_DIVR;
          end
        end
        ST_DIVR: begin
          if (div_last) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        // Clear the staged result and take the transaction in
        res_error   <= 1'b0;
        res_neg     <= 1'b0;
        res_whole   <= '0;
        res_tenths  <= '0;
        res_half    <= '0;
        res_refresh <= 1'b0;
        res_row     <= '0;
        res_min     <= '0;
        res_max     <= '0;
        sum_cnt     <= '0;
        acc         <= '0;
        scan_cnt    <= '0;
        lo          <= LVL_W'(scale_floor);
        hi          <= LVL_W'(scale_ceiling);
        col_idx     <= idx_wrapped[HIST_AW-1:0];
        if (request.valid && request.opcode == OP_SAMPLE) begin
          if (request.raw_sample == '0) begin
            res_error <= 1'b1;
          end else begin
            recent[ridx] <= conv_half;
            res_neg      <= raw_neg;
            res_whole    <= conv_whole;
            res_tenths   <= conv_tenths;
            res_half     <= conv_half;
            res_refresh  <= conv_refresh;
          end
        end
      end
      ST_SUM: begin
        acc     <= alu_y[ACC_W-1:0];
        sum_cnt <= sum_cnt + 1'b1;
      end
      ST_AVG_MUL: begin
        avg_neg <= acc[ACC_W-1];
        prod    <= PROD_W'(acc_mag) * PROD_W'(RECIP);
      end
      ST_SCAN: begin
        scan_cnt <= scan_cnt + 1'b1;
      end
      ST_FETCH: begin
        // Scale limits are final here; set up the row division
        dvd     <= DVD_W'(d_clamped) * DVD_W'(GRAPH_ROWS - 1);
        divisor <= diff_full[DIFF_W-1:0];
        rem     <= '0;
        quot    <= '0;
        div_cnt <= '0;
        res_min <= SCALE_W'(lo >>> 1);
        res_max <= SCALE_W'(hi >>> 1);
      end
      ST_DIVR: begin
        // One restoring-division step per cycle
        rem     <= div_ge ? alu_y[DIFF_W-1:0] : rem_sh[DIFF_W-1:0];
        quot    <= {quot[DVD_W-2:0], div_ge};
        dvd     <= {dvd[DVD_W-2:0], 1'b0};
        div_cnt <= div_cnt + 1'b1;
        if (div_last) begin
          res_row <= {quot[ROW_OUT_W-2:0], div_ge};
        end
      end
      default: ;
    endcase

    // Track minimum and maximum of each ring entry as its read returns
    if (scan_pend) begin
      if (ring_v < lo) begin
        lo <= ring_v;
      end
      if (ring_v > hi) begin
        hi <= ring_v;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.sensor_error    <= res_error;
      result.is_negative     <= res_neg;
      result.whole_degrees   <= res_whole;
      result.tenths          <= res_tenths;
      result.half_degrees    <= res_half;
      result.refresh_due     <= res_refresh;
      result.graph_row       <= res_row;
      result.scale_min_whole <= res_min;
      result.scale_max_whole <= res_max;
    end
  end

  assign result.valid = out_valid;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `THTC_ASSERT_NEXT(a_zero_sample_flags, request.valid && request.ready && request.opcode == OP_SAMPLE && request.raw_sample == '0, state == ST_DONE && res_error, "zero sample did not go straight to an error result")
  `THTC_ASSERT_SAME(a_scale_ordered, state == ST_FETCH, lo <= hi, "graph minimum above graph maximum after scan")
  `THTC_ASSERT_NEXT(a_row_in_range, state == ST_DIVR && div_last, quot <= DVD_W'(GRAPH_ROWS - 1), "graph row quotient out of range")
  `THTC_ASSERT_SAME(a_pointers_in_range, !rst, ridx < RIDX_W'(AVG_COUNT) && write_pos < HIST_AW'(HISTORY_DEPTH), "buffer or ring pointer out of range")

endmodule

`default_nettype wire

/* src/thtc_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none

module thtc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for temperature_history_tracker_core: sample conversion,
// six-sample averaging into the history ring and graph column queries.
// Depends on thtc_pkg, the thtc interfaces and the core RTL.
`timescale 1ns / 1ps

module testbench;
  import thtc_pkg::*;

  // Spare register indexes: writes to them must leave the scale untouched
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  localparam int PHASES          = 5;
  localparam int ITEMS_PER_PHASE = 246;
  localparam int QUERY_PERCENT   = 6;
  localparam int SETTLE_CYCLES   = HISTORY_DEPTH + 32;
  localparam int OPENING_ROWS    = 21;

  // One result transaction as the block presents it
  typedef struct packed {
    logic                      sensor_error;
    logic                      is_negative;
    logic [WHOLE_W-1:0]        whole_degrees;
    logic [TENTHS_W-1:0]       tenths;
    logic signed [HALF_W-1:0]  half_degrees;
    logic                      refresh_due;
    logic [ROW_OUT_W-1:0]      graph_row;
    logic signed [SCALE_W-1:0] scale_min_whole;
    logic signed [SCALE_W-1:0] scale_max_whole;
  } reading_t;

  // Directed request; typed rows carry a hand-written reading
  typedef struct packed {
    logic                op;
    logic [RAW_W-1:0]    raw;
    logic [COLUMN_W-1:0] col;
    logic                typed;
    reading_t            want;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst;
  logic take_result = 1'b0;
  int   stall_clock = 0;
  int   mismatches = 0;
  int   burst_left = 0;
  int   drift = 400;

  // Tracker state as predicted
  logic signed [HALF_W-1:0] window [AVG_COUNT] = '{default: '0};
  int                       window_fill = 0;
  logic signed [HALF_W-1:0] history [HISTORY_DEPTH] = '{default: '0};
  int                       history_head = 0;
  int                       floor_half = FLOOR_RESET;
  int                       ceiling_half = CEILING_RESET;

  reading_t readings_due [$];

  directed_row_t opening_rows [OPENING_ROWS] = '{
    // empty ring, reset scale, then the clamped column
    '{OP_QUERY, 16'h0000, 8'd0, 1'b1,
      '{1'b0, 1'b0, 7'd0, 4'd0, 8'sd0, 1'b0, 5'd0, 7'sd0, 7'sd10}},
    '{OP_QUERY, 16'h0000, 8'd255, 1'b1,
      '{1'b0, 1'b0, 7'd0, 4'd0, 8'sd0, 1'b0, 5'd0, 7'sd0, 7'sd10}},
    // zero word flags an error only
    '{OP_SAMPLE, 16'h0000, 8'd0, 1'b1,
      '{1'b1, 1'b0, 7'd0, 4'd0, 8'sd0, 1'b0, 5'd0, 7'sd0, 7'sd0}},
    // upper bits alone read as zero degrees
    '{OP_SAMPLE, 16'hF000, 8'd0, 1'b1,
      '{1'b0, 1'b0, 7'd0, 4'd0, 8'sd0, 1'b0, 5'd0, 7'sd0, 7'sd0}},
    // most negative word saturates both magnitudes
    '{OP_SAMPLE, 16'h0800, 8'd0, 1'b1,
      '{1'b0, 1'b1, 7'd127, 4'd0, 8'sh80, 1'b0, 5'd0, 7'sd0, 7'sd0}},
    // most positive word; third sample of the group
    '{OP_SAMPLE, 16'h07FF, 8'd0, 1'b1,
      '{1'b0, 1'b0, 7'd127, 4'd9, 8'sd127, 1'b1, 5'd0, 7'sd0, 7'sd0}},
    '{OP_SAMPLE, 16'h0000, 8'd17, 1'b1,
      '{1'b1, 1'b0, 7'd0, 4'd0, 8'sd0, 1'b0, 5'd0, 7'sd0, 7'sd0}},
    '{OP_SAMPLE, 16'h07F0, 8'd0, 1'b1,
      '{1'b0, 1'b0, 7'd127, 4'd0, 8'sd127, 1'b0, 5'd0, 7'sd0, 7'sd0}},
    '{OP_SAMPLE, 16'h0FFF, 8'd0, 1'b1,
      '{1'b0, 1'b1, 7'd0, 4'd0, 8'sd0, 1'b0, 5'd0, 7'sd0, 7'sd0}},
    // sixth sample closes the group
    '{OP_SAMPLE, 16'h0001, 8'd0, 1'b1,
      '{1'b0, 1'b0, 7'd0, 4'd0, 8'sd0, 1'b1, 5'd0, 7'sd0, 7'sd0}},
    '{OP_QUERY,  16'hFFFF, 8'd239, 1'b0, '0},
    '{OP_QUERY,  16'h0000, 8'd0,   1'b0, '0},
    '{OP_SAMPLE, 16'hFC90, 8'd0,   1'b0, '0},
    '{OP_SAMPLE, 16'h0191, 8'd0,   1'b0, '0},
    '{OP_SAMPLE, 16'h0FF8, 8'd0,   1'b0, '0},
    '{OP_SAMPLE, 16'h8008, 8'd0,   1'b0, '0},
    '{OP_SAMPLE, 16'h4A5F, 8'd0,   1'b0, '0},
    '{OP_SAMPLE, 16'h07D0, 8'd0,   1'b0, '0},
    '{OP_QUERY,  16'h1234, 8'd238, 1'b0, '0},
    '{OP_QUERY,  16'h0000, 8'd240, 1'b0, '0},
    '{OP_QUERY,  16'h0000, 8'd128, 1'b0, '0}
  };

  thtc_req_if request_ch ();
  thtc_rsp_if result_ch ();
  thtc_cfg_if scale_ch ();

  assign result_ch.ready = take_result;

  temperature_history_tracker_core DUT (
    .clk     (clk),
    .rst     (rst),
    .request (request_ch),
    .result  (result_ch),
    .cfg     (scale_ch)
  );

  always #4 clk = ~clk;

  // Advance the predicted tracker by one request and return its reading
  function automatic reading_t advance_tracker(input logic op, input logic [RAW_W-1:0] raw,
                                               input logic [COLUMN_W-1:0] col);
    reading_t    r;
    logic [11:0] low;
    logic [12:0] mag;
    int          whole, tenth, half, sum, avg, lo, hi, span, pos, offset, row;
    r = '0;
    if (op == OP_SAMPLE) begin
      if (raw == '0) begin
        r.sensor_error = 1'b1;
      end else begin
        low = raw[11:0];
        mag = low[11] ? 13'h1000 - {1'b0, low} : {1'b0, low};
        whole = mag >> 4;
        if (whole > WHOLE_MAX) whole = WHOLE_MAX;
        tenth = (int'(mag[3:0]) * 10) / 16;
        half = mag >> 3;
        if (low[11]) half = -half;
        if (half > HALF_POS_MAX) half = HALF_POS_MAX;
        if (half < -HALF_NEG_MAX) half = -HALF_NEG_MAX;
        r.is_negative   = low[11];
        r.whole_degrees = whole[6:0];
        r.tenths        = tenth[3:0];
        r.half_degrees  = half[7:0];

        // Collect the group; a full group pushes its mean into the ring
        window[window_fill] = half[7:0];
        window_fill++;
        r.refresh_due = (window_fill == AVG_COUNT / 2) || (window_fill == AVG_COUNT);
        if (window_fill == AVG_COUNT) begin
          window_fill = 0;
          sum = 0;
          foreach (window[i]) sum += window[i];
          avg = sum / AVG_COUNT;
          history[history_head] = avg[7:0];
          history_head = (history_head + 1) % HISTORY_DEPTH;
        end
      end
    end else begin
      // Widen the scale over the whole ring, then place the column
      lo = floor_half;
      hi = ceiling_half;
      foreach (history[i]) begin
        if (history[i] < lo) lo = history[i];
        if (history[i] > hi) hi = history[i];
      end
      span = hi - lo;
      pos = (col >= HISTORY_DEPTH) ? HISTORY_DEPTH - 1 : col;
      pos = (pos + history_head) % HISTORY_DEPTH;
      row = 0;
      if (span > 0) begin
        offset = history[pos] - lo;
        if (offset < 0) offset = 0;
        row = (offset * (GRAPH_ROWS - 1)) / span;
      end
      r.graph_row = row[4:0];
      lo = lo >>> 1;
      hi = hi >>> 1;
      r.scale_min_whole = lo[6:0];
      r.scale_max_whole = hi[6:0];
    end
    return r;
  endfunction

  // Pick a sensor word: mostly a slow drift, some noise and edge values
  function automatic logic [RAW_W-1:0] pick_raw_word();
    int          roll;
    logic [3:0]  upper;
    roll = $urandom_range(0, 99);
    if (roll < 2) return '0;
    if (roll < 8) begin
      case ($urandom_range(0, 4))
        0: return 16'h0800;
        1: return {8'h07, 4'hF, 4'($urandom_range(0, 15))};
        2: return 16'h0FFF;
        3: return 16'h0001;
        default: return 16'hF800;
      endcase
    end
    if (roll < 28) return 16'($urandom);
    drift += int'($urandom_range(0, 80)) - 40;
    if (drift < -880) drift = -880;
    if (drift > 2000) drift = 2000;
    upper = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(1, 15)) : 4'h0;
    return {upper, drift[11:0]};
  endfunction

  function automatic void compare_field(input string label, input logic signed [31:0] want,
                                        input logic signed [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d, got %0d", $time, label, want, got);
      mismatches++;
    end
  endfunction

  // Offer one request in bursts, predict its reading once it is taken
  task automatic send_request(input logic op, input logic [RAW_W-1:0] raw,
                              input logic [COLUMN_W-1:0] col, input logic typed,
                              input reading_t want);
    int       idle;
    reading_t predicted;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (idle > 0) begin
        request_ch.valid <= 1'b0;
        repeat (idle) @(posedge clk);
      end
    end
    burst_left--;
    request_ch.valid      <= 1'b1;
    request_ch.opcode     <= op;
    request_ch.raw_sample <= raw;
    request_ch.column     <= col;
    do @(posedge clk); while (!request_ch.ready);
    predicted = advance_tracker(op, raw, col);
    readings_due.push_back(typed ? want : predicted);
  endtask

  // Hold valid until the register transaction is taken
  task automatic post_register(input logic [CFG_IDX_W-1:0] index,
                               input logic [CFG_DATA_W-1:0] data);
    scale_ch.valid <= 1'b1;
    scale_ch.index <= index;
    scale_ch.data  <= data;
    do @(posedge clk); while (!scale_ch.ready);
    if (index == REG_SCALE_FLOOR) floor_half = $signed(data);
    else if (index == REG_SCALE_CEILING) ceiling_half = data[CEIL_W-1:0];
  endtask

  task automatic program_scale(input int floor_val, input int ceiling_val);
    post_register(REG_SCALE_FLOOR, floor_val[7:0]);
    post_register(REG_SCALE_CEILING, {1'b0, ceiling_val[6:0]});
    post_register($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
                  8'($urandom_range(0, 255)));
    scale_ch.valid <= 1'b0;
  endtask

  // Drop valid and wait for every outstanding reading
  task automatic drain_results();
    request_ch.valid <= 1'b0;
    while (readings_due.size() != 0) @(posedge clk);
  endtask

  // Check each result transaction and stall on a pattern of modes
  always @(posedge clk) begin : result_check
    reading_t want;
    stall_clock <= stall_clock + 1;
    if (rst) begin
      take_result <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (readings_due.size() == 0) begin
          $display("%0t: result transaction with no reading outstanding", $time);
          mismatches++;
        end else begin
          want = readings_due.pop_front();
          compare_field("sensor_error", want.sensor_error, result_ch.sensor_error);
          compare_field("is_negative", want.is_negative, result_ch.is_negative);
          compare_field("whole_degrees", want.whole_degrees, result_ch.whole_degrees);
          compare_field("tenths", want.tenths, result_ch.tenths);
          compare_field("half_degrees", want.half_degrees, result_ch.half_degrees);
          compare_field("refresh_due", want.refresh_due, result_ch.refresh_due);
          compare_field("graph_row", want.graph_row, result_ch.graph_row);
          compare_field("scale_min_whole", want.scale_min_whole, result_ch.scale_min_whole);
          compare_field("scale_max_whole", want.scale_max_whole, result_ch.scale_max_whole);
        end
      end
      case (stall_clock[10:9])
        2'd0:    take_result <= 1'b1;
        2'd1:    take_result <= ($urandom_range(0, 3) != 0);
        2'd2:    take_result <= (stall_clock[2:0] == 3'd0);
        default: take_result <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  // Directed table, then random phases under different scale settings
  initial begin : stimulus
    int phase;
    rst                   <= 1'b1;
    request_ch.valid      <= 1'b0;
    request_ch.opcode     <= OP_SAMPLE;
    request_ch.raw_sample <= '0;
    request_ch.column     <= '0;
    scale_ch.valid        <= 1'b0;
    scale_ch.index        <= REG_SCALE_FLOOR;
    scale_ch.data         <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (opening_rows[i])
      send_request(opening_rows[i].op, opening_rows[i].raw, opening_rows[i].col,
                   opening_rows[i].typed, opening_rows[i].want);
    drain_results();

    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:          program_scale(-128, 127);
        1:          program_scale(0, 1);
        PHASES - 1: program_scale(FLOOR_RESET, CEILING_RESET);
        default:    program_scale(0 - int'($urandom_range(0, 128)), $urandom_range(1, 127));
      endcase
      repeat (ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 99) < QUERY_PERCENT)
          send_request(OP_QUERY, 16'($urandom), 8'($urandom_range(0, 255)), 1'b0, '0);
        else
          send_request(OP_SAMPLE, pick_raw_word(), 8'($urandom_range(0, 255)), 1'b0, '0);
      end
      drain_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && readings_due.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // Guard against a hung handshake
  initial begin : watchdog
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+src
src/thtc_pkg.sv
src/thtc_if.sv
src/thtc_ram.sv
src/temperature_history_tracker_core.sv
tb/testbench.sv
